/* design/gtr_pkg.sv */
// gtr_pkg: shared types, constants, font table and helpers for the glyph rasterizer
// used by gtr_scan, gtr_emit and glyph_text_rasterizer; no dependencies
package gtr_pkg;

  // screen size used for clipping single pixels
  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 240;

  // font cell geometry
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned CNT_W       = $clog2(GLYPH_BITS);
  localparam int unsigned COL_W       = $clog2(GLYPH_COLS);

  // character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7F;
  localparam logic [7:0] CHAR_SUBST   = 8'h3F;

  // scan sequencer states
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_FLUSH
  } scan_state_e;

  // one dot on its way to the output
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [4:0]  size;
    logic        [31:0] color;
  } dot_t;

  // control from scanner to output stage
  typedef struct packed {
    logic dot_valid;
    logic flush;
  } scan_ctl_t;

  // 5x7 font, seven row bytes per glyph, top row in the high byte
  localparam logic [55:0] GLYPH_ROM [GLYPH_COUNT] = '{
    56'h00000000000000, 56'h04040404040004, 56'h0A0A0000000000, 56'h0A1F0A0A1F0A00,
    56'h040F140E051E04, 56'h18190204081303, 56'h0814140815120D, 56'h04040000000000,
    56'h02040808080402, 56'h08040202020408, 56'h0004150E150400, 56'h0004041F040400,
    56'h00000000000408, 56'h0000001F000000, 56'h00000000000004, 56'h01020204080810,
    56'h0E11131519110E, 56'h040C040404040E, 56'h0E11010608101F, 56'h0E11010601110E,
    56'h02060A121F0202, 56'h1F101E0101110E, 56'h0608101E11110E, 56'h1F010204080808,
    56'h0E11110E11110E, 56'h0E11110F01020C, 56'h00000400000400, 56'h00000400000408,
    56'h02040810080402, 56'h00001F001F0000, 56'h08040201020408, 56'h0E110106040004,
    56'h0E11171517100E, 56'h0E11111F111111, 56'h1E11111E11111E, 56'h0E11101010110E,
    56'h1E11111111111E, 56'h1F10101E10101F, 56'h1F10101E101010, 56'h0E11101711110F,
    56'h1111111F111111, 56'h0E04040404040E, 56'h0702020202120C, 56'h11121418141211,
    56'h1010101010101F, 56'h111B1515111111, 56'h11191513111111, 56'h0E11111111110E,
    56'h1E11111E101010, 56'h0E11111115120D, 56'h1E11111E141211, 56'h0E11100E01110E,
    56'h1F040404040404, 56'h1111111111110E, 56'h111111110A0A04, 56'h11111115151B11,
    56'h11110A040A1111, 56'h11110A04040404, 56'h1F01020408101F, 56'h0E08080808080E,
    56'h10080804020201, 56'h0E02020202020E, 56'h040A1100000000, 56'h0000000000001F,
    56'h08040000000000, 56'h00000E010F110F, 56'h10101E1111111E, 56'h00000E1110110E,
    56'h01010F1111110F, 56'h00000E111F100E, 56'h06081E08080808, 56'h00000F110F010E,
    56'h10101E11111111, 56'h04000C0404040E, 56'h0200060202120C, 56'h10101214181412,
    56'h0C04040404040E, 56'h00001A15151111, 56'h00001E11111111, 56'h00000E1111110E,
    56'h00001E111E1010, 56'h00000F110F0101, 56'h00001619101010, 56'h00000F100E011E,
    56'h08081E08080906, 56'h0000111111110F, 56'h00001111110A04, 56'h0000111115150A,
    56'h0000110A040A11, 56'h000011110F010E, 56'h00001F0204081F, 56'h02040408040402,
    56'h04040404040404, 56'h08040402040408, 56'h00000815020000, 56'h00000000000000
  };

  // glyph bits of a character, top-left dot in the msb, row after row
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    logic [7:0]            c;
    logic [6:0]            idx;
    logic [55:0]           rows;
    logic [GLYPH_BITS-1:0] bits;
    c = ((code < CHAR_FIRST) || (code > CHAR_LAST)) ? CHAR_SUBST : code;
    idx = 7'(c - CHAR_FIRST);
    rows = GLYPH_ROM[idx];
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      bits[GLYPH_BITS-1-GLYPH_COLS*r -: GLYPH_COLS] = rows[55-8*r-3 -: GLYPH_COLS];
    end
    return bits;
  endfunction

  // clamp a 17-bit signed value to the 16-bit signed range
  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* design/gtr_scan.sv */
// gtr_scan: walks the 35 font bits of one glyph through a shift register,
// stepping dot coordinates by the scale; depends on gtr_pkg
module gtr_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  base_x_i,
  input  logic signed [15:0]  base_y_i,
  input  logic        [4:0]   scale_i,
  input  logic        [31:0]  color_i,
  input  logic        [7:0]   char_code_i,
  input  logic                adv_i,
  output logic                busy_o,
  output gtr_pkg::scan_ctl_t  ctl_o,
  output gtr_pkg::dot_t       dot_o
);
  import gtr_pkg::*;

  scan_state_e            state_q, state_d;
  logic [GLYPH_BITS-1:0]  bits_q, bits_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [COL_W-1:0]       col_q, col_d;
  logic signed [16:0]     x_q, x_d, y_q, y_d, base_x_q, base_x_d;
  logic [4:0]             scale_q, scale_d;
  logic [31:0]            color_q, color_d;
  logic                   visible;
  logic                   on_screen;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    bits_q   <= bits_d;
    cnt_q    <= cnt_d;
    col_q    <= col_d;
    x_q      <= x_d;
    y_q      <= y_d;
    base_x_q <= base_x_d;
    scale_q  <= scale_d;
    color_q  <= color_d;
  end

  // clip test, only applied at single-pixel size
  assign on_screen = !x_q[16] && (x_q < 17'(SCREEN_WIDTH)) &&
                     !y_q[16] && (y_q < 17'(SCREEN_HEIGHT));
  assign visible = bits_q[GLYPH_BITS-1] && ((scale_q != 5'd1) || on_screen);

  // sequencer and coordinate stepping
  always_comb begin
    state_d  = state_q;
    bits_d   = bits_q;
    cnt_d    = cnt_q;
    col_d    = col_q;
    x_d      = x_q;
    y_d      = y_q;
    base_x_d = base_x_q;
    scale_d  = scale_q;
    color_d  = color_q;
    ctl_o    = '0;
    unique case (state_q)
      SCAN_IDLE: begin
        if (start_i) begin
          bits_d   = glyph_bits(char_code_i);
          cnt_d    = '0;
          col_d    = '0;
          x_d      = 17'(base_x_i);
          y_d      = 17'(base_y_i);
          base_x_d = 17'(base_x_i);
          scale_d  = scale_i;
          color_d  = color_i;
          state_d  = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (adv_i) begin
          ctl_o.dot_valid = visible;
          bits_d = {bits_q[GLYPH_BITS-2:0], 1'b0};
          if (col_q == COL_W'(GLYPH_COLS - 1)) begin
            col_d = '0;
            x_d   = base_x_q;
            y_d   = y_q + 17'(scale_q);
          end else begin
            col_d = col_q + 1'b1;
            x_d   = x_q + 17'(scale_q);
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNT_W'(GLYPH_BITS - 1)) begin
            state_d = SCAN_FLUSH;
          end
        end
      end
      SCAN_FLUSH: begin
        if (adv_i) begin
          ctl_o.flush = 1'b1;
          state_d     = SCAN_IDLE;
        end
      end
      default: state_d = SCAN_IDLE;
    endcase
  end

  assign busy_o      = (state_q != SCAN_IDLE);
  assign dot_o.x     = sat16(x_q);
  assign dot_o.y     = sat16(y_q);
  assign dot_o.size  = scale_q;
  assign dot_o.color = color_q;

endmodule

/* design/gtr_emit.sv */
// gtr_emit: holds back one dot so the final dot of a glyph can be marked,
// and drives the output register; depends on gtr_pkg
module gtr_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtr_pkg::scan_ctl_t ctl_i,
  input  gtr_pkg::dot_t      dot_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] dot_x_o,
  output logic signed [15:0] dot_y_o,
  output logic        [4:0]  dot_size_o,
  output logic        [31:0] dot_color_o,
  output logic               last_of_char_o
);
  import gtr_pkg::*;

  logic pend_valid_q, pend_valid_d;
  dot_t pend_q, pend_d;
  logic out_valid_q, out_valid_d;
  dot_t out_q, out_d;
  logic last_q, last_d;

  // output register is free when empty or being taken
  assign ready_o = !out_valid_q || !out_stall_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  // move the held dot out when a newer one arrives or the glyph ends
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    last_d       = last_q;
    if (ready_o) begin
      out_valid_d = 1'b0;
      if (ctl_i.dot_valid) begin
        if (pend_valid_q) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          last_d      = 1'b0;
        end
        pend_valid_d = 1'b1;
        pend_d       = dot_i;
      end else if (ctl_i.flush && pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        last_d       = 1'b1;
        pend_valid_d = 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dot_x_o        = out_q.x;
  assign dot_y_o        = out_q.y;
  assign dot_size_o     = out_q.size;
  assign dot_color_o    = out_q.color;
  assign last_of_char_o = last_q;

endmodule

/* design/glyph_text_rasterizer.sv */
// glyph_text_rasterizer: top level, text cursor and character handling
// depends on gtr_pkg, gtr_scan and gtr_emit
//
// Input channel: one character word per handshake (in_valid_i / in_stall_o),
// with start position, scale and color. first_of_text_i loads the cursor and
// line start from start_x_i / start_y_i before the character is handled.
// Output channel: one dot word per handshake (out_valid_o / out_stall_i),
// giving the pixel or box corner, its size and color; last_of_char_o marks
// the final dot of a character. Characters with no visible dot give none.
// Sequence: a drawn character is handled from acceptance in order: the glyph
// is loaded, the font shift register moves one bit for each of the 35 font
// bits while the output stage is ready, and a closing step releases the final
// dot. No new character is accepted until then. A newline moves the cursor
// and emits nothing. A dot is held back one step so the final one can be
// marked: it enters the output register when the next visible dot of its
// character is scanned or at the closing step.
// When the receiver stalls, the scan holds its place and resumes without
// loss. Reset clears the cursor and line start to zero and empties the
// output.
module glyph_text_rasterizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               first_of_text_i,
  input  logic signed [11:0] start_x_i,
  input  logic signed [11:0] start_y_i,
  input  logic        [7:0]  char_code_i,
  input  logic        [4:0]  pixel_scale_i,
  input  logic        [31:0] draw_color_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] dot_x_o,
  output logic signed [15:0] dot_y_o,
  output logic        [4:0]  dot_size_o,
  output logic        [31:0] dot_color_o,
  output logic               last_of_char_o
);
  import gtr_pkg::*;

  logic signed [15:0] cursor_x_q, cursor_x_d;
  logic signed [15:0] cursor_y_q, cursor_y_d;
  logic signed [15:0] line_x_q, line_x_d;
  logic signed [15:0] start_x, start_y, base_x, base_y;
  logic        [4:0]  scale;
  logic        [7:0]  step_x, step_y;
  logic               accept;
  logic               newline;
  logic               start;
  logic               busy;
  logic               adv;
  scan_ctl_t          ctl;
  dot_t               dot;

  assign accept  = in_valid_i && !in_stall_o;
  assign newline = (char_code_i == CHAR_NEWLINE);
  assign start   = accept && !newline;
  assign in_stall_o = busy;

  // effective origin and scale of this character
  assign start_x = 16'(start_x_i);
  assign start_y = 16'(start_y_i);
  assign base_x  = first_of_text_i ? start_x : cursor_x_q;
  assign base_y  = first_of_text_i ? start_y : cursor_y_q;
  assign scale   = (pixel_scale_i == 5'd0) ? 5'd1 : pixel_scale_i;
  assign step_x  = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
  assign step_y  = {scale, 3'b000};

  // cursor update
  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    line_x_d   = line_x_q;
    if (accept) begin
      if (first_of_text_i) begin
        line_x_d = start_x;
      end
      if (newline) begin
        cursor_x_d = first_of_text_i ? start_x : line_x_q;
        cursor_y_d = sat16(17'(base_y) + 17'(step_y));
      end else begin
        cursor_x_d = sat16(17'(base_x) + 17'(step_x));
        cursor_y_d = base_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      line_x_q   <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      line_x_q   <= line_x_d;
    end
  end

  // font scan
  gtr_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .base_x_i    (base_x),
    .base_y_i    (base_y),
    .scale_i     (scale),
    .color_i     (draw_color_i),
    .char_code_i (char_code_i),
    .adv_i       (adv),
    .busy_o      (busy),
    .ctl_o       (ctl),
    .dot_o       (dot)
  );

  // dot output stage
  gtr_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .dot_i          (dot),
    .ready_o        (adv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dot_x_o        (dot_x_o),
    .dot_y_o        (dot_y_o),
    .dot_size_o     (dot_size_o),
    .dot_color_o    (dot_color_o),
    .last_of_char_o (last_of_char_o)
  );

endmodule

/* tb/sv/glyph_dot_checker.sv */
`timescale 1ns / 1ps
// glyph_dot_checker: watches the character and dot channels of glyph_text_rasterizer,
// predicts the dot words of each accepted character and compares them in order
// depends on gtr_pkg for character codes and screen size
module glyph_dot_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               first_of_text_i,
  input  logic signed [11:0] start_x_i,
  input  logic signed [11:0] start_y_i,
  input  logic        [7:0]  char_code_i,
  input  logic        [4:0]  pixel_scale_i,
  input  logic        [31:0] draw_color_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] dot_x_i,
  input  logic signed [15:0] dot_y_i,
  input  logic        [4:0]  dot_size_i,
  input  logic        [31:0] dot_color_i,
  input  logic               last_of_char_i,
  output int unsigned        fail_count_o,
  output int unsigned        dots_pending_o
);
  import gtr_pkg::*;

  // font cells for codes 32..127, top row in the high byte, dot columns in bits 4..0
  localparam logic [55:0] CHAR_FONT [96] = '{
    56'h00000000000000, 56'h04040404040004, 56'h0A0A0000000000, 56'h0A1F0A0A1F0A00,
    56'h040F140E051E04, 56'h18190204081303, 56'h0814140815120D, 56'h04040000000000,
    56'h02040808080402, 56'h08040202020408, 56'h0004150E150400, 56'h0004041F040400,
    56'h00000000000408, 56'h0000001F000000, 56'h00000000000004, 56'h01020204080810,
    56'h0E11131519110E, 56'h040C040404040E, 56'h0E11010608101F, 56'h0E11010601110E,
    56'h02060A121F0202, 56'h1F101E0101110E, 56'h0608101E11110E, 56'h1F010204080808,
    56'h0E11110E11110E, 56'h0E11110F01020C, 56'h00000400000400, 56'h00000400000408,
    56'h02040810080402, 56'h00001F001F0000, 56'h08040201020408, 56'h0E110106040004,
    56'h0E11171517100E, 56'h0E11111F111111, 56'h1E11111E11111E, 56'h0E11101010110E,
    56'h1E11111111111E, 56'h1F10101E10101F, 56'h1F10101E101010, 56'h0E11101711110F,
    56'h1111111F111111, 56'h0E04040404040E, 56'h0702020202120C, 56'h11121418141211,
    56'h1010101010101F, 56'h111B1515111111, 56'h11191513111111, 56'h0E11111111110E,
    56'h1E11111E101010, 56'h0E11111115120D, 56'h1E11111E141211, 56'h0E11100E01110E,
    56'h1F040404040404, 56'h1111111111110E, 56'h111111110A0A04, 56'h11111115151B11,
    56'h11110A040A1111, 56'h11110A04040404, 56'h1F01020408101F, 56'h0E08080808080E,
    56'h10080804020201, 56'h0E02020202020E, 56'h040A1100000000, 56'h0000000000001F,
    56'h08040000000000, 56'h00000E010F110F, 56'h10101E1111111E, 56'h00000E1110110E,
    56'h01010F1111110F, 56'h00000E111F100E, 56'h06081E08080808, 56'h00000F110F010E,
    56'h10101E11111111, 56'h04000C0404040E, 56'h0200060202120C, 56'h10101214181412,
    56'h0C04040404040E, 56'h00001A15151111, 56'h00001E11111111, 56'h00000E1111110E,
    56'h00001E111E1010, 56'h00000F110F0101, 56'h00001619101010, 56'h00000F100E011E,
    56'h08081E08080906, 56'h0000111111110F, 56'h00001111110A04, 56'h0000111115150A,
    56'h0000110A040A11, 56'h000011110F010E, 56'h00001F0204081F, 56'h02040408040402,
    56'h04040404040404, 56'h08040402040408, 56'h00000815020000, 56'h00000000000000
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [4:0]  size;
    logic        [31:0] color;
    logic               last;
  } dot_word_t;

  dot_word_t   dot_queue [$];
  dot_word_t   want;
  int          pen_x;
  int          pen_y;
  int          line_x;
  int unsigned fail_count = 0;

  initial begin
    fail_count_o   = 0;
    dots_pending_o = 0;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // cursor update and dot list of one character word
  task automatic rasterize_char(input logic first, input logic signed [11:0] sx,
                                input logic signed [11:0] sy, input logic [7:0] code,
                                input logic [4:0] scale_in, input logic [31:0] color);
    int          scale;
    int          px;
    int          py;
    int          emitted;
    logic [7:0]  glyph;
    logic [55:0] font_cell;
    logic [7:0]  row_bits;
    dot_word_t   d;
    emitted = 0;
    if (first) begin
      pen_x  = sx;
      line_x = sx;
      pen_y  = sy;
    end
    scale = (scale_in == 5'd0) ? 1 : int'(scale_in);
    // newline: back to line start, one text line down, nothing drawn
    if (code == CHAR_NEWLINE) begin
      pen_x = line_x;
      pen_y = clamp16(pen_y + 8 * scale);
      return;
    end
    glyph     = ((code < CHAR_FIRST) || (code > CHAR_LAST)) ? CHAR_SUBST : code;
    font_cell = CHAR_FONT[glyph - CHAR_FIRST];
    for (int row = 0; row < 7; row++) begin
      row_bits = font_cell[55 - 8 * row -: 8];
      for (int col = 0; col < 5; col++) begin
        if (row_bits[4 - col]) begin
          px = clamp16(pen_x + col * scale);
          py = clamp16(pen_y + row * scale);
          // single pixels are clipped to the screen, boxes never
          if (scale != 1 || (px >= 0 && px < int'(SCREEN_WIDTH) &&
                             py >= 0 && py < int'(SCREEN_HEIGHT))) begin
            d.x     = 16'(px);
            d.y     = 16'(py);
            d.size  = 5'(scale);
            d.color = color;
            d.last  = 1'b0;
            dot_queue.push_back(d);
            emitted++;
          end
        end
      end
    end
    if (emitted > 0) dot_queue[dot_queue.size() - 1].last = 1'b1;
    pen_x = clamp16(pen_x + 6 * scale);
  endtask

  task automatic check_field(input string name, input logic signed [32:0] exp_v,
                             input logic signed [32:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x  = 0;
      pen_y  = 0;
      line_x = 0;
      dot_queue.delete();
    end else begin
      // predict the dots of an accepted character word
      if (in_valid_i && !in_stall_i) begin
        rasterize_char(first_of_text_i, start_x_i, start_y_i, char_code_i,
                       pixel_scale_i, draw_color_i);
      end
      // compare an accepted dot word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (dot_queue.size() == 0) begin
          $display("%0t: unexpected dot word, expected none, actual x=%0d y=%0d size=%0d",
                   $time, dot_x_i, dot_y_i, dot_size_i);
          fail_count++;
        end else begin
          want = dot_queue.pop_front();
          check_field("dot_x", want.x, dot_x_i);
          check_field("dot_y", want.y, dot_y_i);
          check_field("dot_size", want.size, dot_size_i);
          check_field("dot_color", want.color, dot_color_i);
          check_field("last_of_char", want.last, last_of_char_i);
        end
      end
    end
    dots_pending_o = dot_queue.size();
    fail_count_o   = fail_count;
  end

endmodule

/* tb/sv/tb_glyph_text_rasterizer.sv */
`timescale 1ns / 1ps
// tb_glyph_text_rasterizer: character word stimulus, dot channel stalls and verdict
// depends on gtr_pkg, glyph_text_rasterizer and glyph_dot_checker
module tb_glyph_text_rasterizer;
  import gtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned TOTAL_CHARS  = 100;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURSTY
  } stall_mode_e;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               first_of_text = 1'b0;
  logic signed [11:0] start_x       = '0;
  logic signed [11:0] start_y       = '0;
  logic        [7:0]  char_code     = '0;
  logic        [4:0]  pixel_scale   = '0;
  logic        [31:0] draw_color    = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic signed [15:0] dot_x;
  logic signed [15:0] dot_y;
  logic        [4:0]  dot_size;
  logic        [31:0] dot_color;
  logic               last_of_char;

  int unsigned fail_count;
  int unsigned dots_pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned chars_sent  = 0;
  int unsigned stall_left  = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  glyph_text_rasterizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .first_of_text_i(first_of_text),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .char_code_i    (char_code),
    .pixel_scale_i  (pixel_scale),
    .draw_color_i   (draw_color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dot_x_o        (dot_x),
    .dot_y_o        (dot_y),
    .dot_size_o     (dot_size),
    .dot_color_o    (dot_color),
    .last_of_char_o (last_of_char)
  );

  glyph_dot_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .first_of_text_i(first_of_text),
    .start_x_i      (start_x),
    .start_y_i      (start_y),
    .char_code_i    (char_code),
    .pixel_scale_i  (pixel_scale),
    .draw_color_i   (draw_color),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .dot_x_i        (dot_x),
    .dot_y_i        (dot_y),
    .dot_size_i     (dot_size),
    .dot_color_i    (dot_color),
    .last_of_char_i (last_of_char),
    .fail_count_o   (fail_count),
    .dots_pending_o (dots_pending)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** glyph_text_rasterizer: FAILED **");
      $finish;
    end
  end

  // dot receiver stalls, mode changes every stretch
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left % 16) < 10);
    endcase
  end

  // send one character word in bursts with random gaps, called at a falling edge
  task automatic send_char(input logic first, input logic signed [11:0] sx,
                           input logic signed [11:0] sy, input logic [7:0] code,
                           input logic [4:0] scale, input logic [31:0] color);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
    end
    burst_left--;
    first_of_text <= first;
    start_x       <= sx;
    start_y       <= sy;
    char_code     <= code;
    pixel_scale   <= scale;
    draw_color    <= color;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    @(negedge clk);
  endtask

  initial begin
    int unsigned        run_len;
    logic        [4:0]  run_scale;
    logic        [31:0] run_color;
    logic signed [11:0] org_x;
    logic signed [11:0] org_y;
    logic        [7:0]  code;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset cursor, zero scale, newline, empty glyph, unprintable codes
    send_char(1'b0, 12'sd0, 12'sd0, "A", 5'd1, 32'hFFFF_FFFF);
    send_char(1'b1, 12'sd10, 12'sd20, "H", 5'd0, 32'h0000_0000);
    send_char(1'b0, 12'sd0, 12'sd0, CHAR_NEWLINE, 5'd0, 32'h1234_5678);
    send_char(1'b0, 12'sd0, 12'sd0, "g", 5'd1, 32'h8765_4321);
    send_char(1'b0, 12'sd0, 12'sd0, CHAR_LAST, 5'd1, 32'hA5A5_A5A5);
    send_char(1'b0, 12'sd0, 12'sd0, CHAR_FIRST, 5'd2, 32'h5A5A_5A5A);
    send_char(1'b0, 12'sd0, 12'sd0, 8'h00, 5'd1, 32'h0F0F_0F0F);
    send_char(1'b0, 12'sd0, 12'sd0, 8'hFF, 5'd1, 32'hF0F0_F0F0);
    send_char(1'b0, 12'sd0, 12'sd0, 8'h1F, 5'd2, 32'h0000_FFFF);
    send_char(1'b0, 12'sd0, 12'sd0, 8'h80, 5'd1, 32'hFFFF_0000);
    // extreme origins and scales, clipping at every screen edge
    send_char(1'b1, -12'sd2048, -12'sd2048, "#", 5'd31, 32'hFFFF_FFFF);
    send_char(1'b1, 12'sd2047, 12'sd2047, "#", 5'd1, 32'h0000_0001);
    send_char(1'b1, 12'sd316, 12'sd234, "#", 5'd1, 32'h0000_0002);
    send_char(1'b1, -12'sd2, -12'sd3, "W", 5'd1, 32'h0000_0003);
    send_char(1'b1, 12'sd0, 12'sd0, "~", 5'd16, 32'h0000_0004);
    send_char(1'b0, 12'sd0, 12'sd0, CHAR_NEWLINE, 5'd31, 32'h0000_0005);
    send_char(1'b0, 12'sd0, 12'sd0, "@", 5'd17, 32'h0000_0006);
    send_char(1'b1, -12'sd1, 12'sd239, "|", 5'd1, 32'h0000_0007);
    send_char(1'b1, 12'sh555, 12'shAAA, "@", 5'd5, 32'h5555_AAAA);
    send_char(1'b1, 12'sd100, 12'sd100, CHAR_NEWLINE, 5'd1, 32'hAAAA_5555);
    send_char(1'b0, 12'sd0, 12'sd0, "Z", 5'd1, 32'hCAFE_F00D);
    send_char(1'b0, 12'sd0, 12'sd0, CHAR_SUBST, 5'd3, 32'h0BAD_BEEF);

    // random text runs with some noise words, up to the total word count
    while (chars_sent < TOTAL_CHARS) begin
      if ($urandom_range(0, 9) < 7) begin
        run_len = $urandom_range(1, 8);
        case ($urandom_range(0, 9))
          0, 1:    run_scale = 5'd0;
          7, 8:    run_scale = 5'($urandom_range(2, 4));
          9:       run_scale = 5'($urandom);
          default: run_scale = 5'd1;
        endcase
        run_color = $urandom;
        if ($urandom_range(0, 3) != 0) begin
          org_x = 12'(int'($urandom_range(0, 330)) - 10);
          org_y = 12'(int'($urandom_range(0, 250)) - 10);
        end else begin
          org_x = 12'($urandom);
          org_y = 12'($urandom);
        end
        for (int k = 0; k < run_len; k++) begin
          case ($urandom_range(0, 15))
            0, 1:    code = CHAR_NEWLINE;
            2:       code = 8'($urandom);
            default: code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
          endcase
          if ($urandom_range(0, 7) == 0) run_color = $urandom;
          if (k == 0) begin
            send_char(1'b1, org_x, org_y, code, run_scale, run_color);
          end else begin
            send_char(1'b0, 12'($urandom), 12'($urandom), code, run_scale, run_color);
          end
        end
      end else begin
        send_char(1'($urandom), 12'($urandom), 12'($urandom), 8'($urandom), 5'($urandom),
                  $urandom);
      end
    end
    in_valid <= 1'b0;

    // drain outstanding dots, then give a trailing character time to finish
    while (dots_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** glyph_text_rasterizer: PASSED **");
    end else begin
      $display("** glyph_text_rasterizer: FAILED **");
    end
    $finish;
  end

endmodule
